// File: hw/rtl/asfw_pkg.sv
package asfw_pkg;

    localparam int POS_BITS = 32;
    // offsets past a position can reach region_total + 40
    localparam int OFS_BITS = POS_BITS + 2;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [1:0] OUT_HDR_MISMATCH = 2'd0;
    localparam logic [1:0] OUT_BAD_SIZE     = 2'd1;
    localparam logic [1:0] OUT_UNKNOWN_GUID = 2'd2;
    localparam logic [1:0] OUT_REGION_END   = 2'd3;

    localparam logic [OFS_BITS-1:0] FIRST_SIZE_OFS = OFS_BITS'(16);
    localparam logic [OFS_BITS-1:0] GUID_LEN       = OFS_BITS'(16);
    localparam logic [OFS_BITS-1:0] SIZE_LEN       = OFS_BITS'(8);
    localparam logic [OFS_BITS-1:0] MIN_OBJ_SIZE   = OFS_BITS'(24);
    localparam logic [OFS_BITS-1:0] NEXT_GUID_GAP  = OFS_BITS'(40);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SIZE,
        PH_GUID
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        region_start;
        logic        region_end;
        logic [31:0] region_bytes;
    } in_item_t;

    typedef struct packed {
        logic [31:0] carve_length;
        logic [1:0]  outcome;
    } out_item_t;

    typedef struct packed {
        logic      emit;
        out_item_t item;
    } step_result_t;

    localparam logic [7:0] HDR_GUID [16] = '{
        8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
        8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C};

    localparam logic [7:0] KNOWN_GUID [4][16] = '{
        '{8'h36, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
          8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C},
        '{8'h90, 8'h08, 8'h00, 8'h33, 8'hB1, 8'hE5, 8'hCF, 8'h11,
          8'h89, 8'hF4, 8'h00, 8'hA0, 8'hC9, 8'h03, 8'h49, 8'hCB},
        '{8'hD3, 8'h29, 8'hE2, 8'hD6, 8'hDA, 8'h35, 8'hD1, 8'h11,
          8'h90, 8'h34, 8'h00, 8'hA0, 8'hC9, 8'h03, 8'h49, 8'hBE},
        '{8'hF8, 8'h03, 8'hB1, 8'hFE, 8'hAD, 8'h12, 8'h64, 8'h4C,
          8'h84, 8'h0F, 8'h2A, 8'h1D, 8'h2F, 8'h7A, 8'hD4, 8'h8C}};

endpackage

// File: hw/rtl/asfw_walker.sv
module asfw_walker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  asfw_pkg::in_item_t    item,
    output asfw_pkg::step_result_t res
);

    logic [asfw_pkg::POS_BITS-1:0] rt_reg, rt_next;
    logic [asfw_pkg::POS_BITS-1:0] pos_reg, pos_next;
    logic [asfw_pkg::OFS_BITS-1:0] sfs_reg, sfs_next;
    logic [asfw_pkg::OFS_BITS-1:0] pss_reg, pss_next;
    logic [asfw_pkg::OFS_BITS-1:0] gs_reg, gs_next;
    logic [63:0]                   obj_reg, obj_next;
    logic [3:0]                    flags_reg, flags_next;
    asfw_pkg::phase_t              phase_reg, phase_next;
    logic                          dec_reg, dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_reg    <= '0;
            pos_reg   <= '0;
            sfs_reg   <= asfw_pkg::FIRST_SIZE_OFS;
            pss_reg   <= '0;
            gs_reg    <= '0;
            obj_reg   <= '0;
            flags_reg <= '1;
            phase_reg <= asfw_pkg::PH_IDLE;
            dec_reg   <= 1'b0;
        end
        else if (step)
        begin
            rt_reg    <= rt_next;
            pos_reg   <= pos_next;
            sfs_reg   <= sfs_next;
            pss_reg   <= pss_next;
            gs_reg    <= gs_next;
            obj_reg   <= obj_next;
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            dec_reg   <= dec_next;
        end
    end

    always_comb
    begin
        logic [asfw_pkg::OFS_BITS-1:0] pos_w;
        logic [asfw_pkg::OFS_BITS-1:0] rt_w;
        logic [asfw_pkg::OFS_BITS-1:0] rel;
        logic [asfw_pkg::OFS_BITS-1:0] limit;
        logic [63:0]                   obj_v;
        logic [3:0]                    flags_v;
        logic                          bad;

        rt_next    = rt_reg;
        pos_next   = pos_reg;
        sfs_next   = sfs_reg;
        pss_next   = pss_reg;
        gs_next    = gs_reg;
        obj_next   = obj_reg;
        flags_next = flags_reg;
        phase_next = phase_reg;
        dec_next   = dec_reg;
        res        = '0;
        rel        = '0;
        obj_v      = '0;
        flags_v    = '0;
        bad        = 1'b0;

        if (item.region_start)
        begin
            if (asfw_pkg::POS_BITS < 32 && item.region_bytes > 32'(asfw_pkg::POS_MAX))
                rt_next = asfw_pkg::POS_MAX;
            else
                rt_next = asfw_pkg::POS_BITS'(item.region_bytes);
            pos_next   = '0;
            sfs_next   = asfw_pkg::FIRST_SIZE_OFS;
            pss_next   = '0;
            gs_next    = '0;
            obj_next   = '0;
            flags_next = '1;
            phase_next = asfw_pkg::PH_HEADER;
            dec_next   = 1'b0;
        end

        pos_w = asfw_pkg::OFS_BITS'(pos_next);
        rt_w  = asfw_pkg::OFS_BITS'(rt_next);
        limit = rt_w - sfs_next + asfw_pkg::GUID_LEN;

        if (phase_next != asfw_pkg::PH_IDLE)
        begin
            if (!dec_next)
            begin
                unique case (phase_next)
                    asfw_pkg::PH_HEADER:
                    begin
                        if (pos_w < asfw_pkg::GUID_LEN)
                        begin
                            if (item.data_byte != asfw_pkg::HDR_GUID[pos_w[3:0]])
                            begin
                                res.emit = 1'b1;
                                res.item.carve_length = '0;
                                res.item.outcome = asfw_pkg::OUT_HDR_MISMATCH;
                                dec_next = 1'b1;
                            end
                            else if (pos_w[3:0] == 4'd15)
                            begin
                                phase_next = asfw_pkg::PH_SIZE;
                                obj_next = '0;
                                if (!(sfs_next + asfw_pkg::MIN_OBJ_SIZE < rt_w))
                                begin
                                    res.emit = 1'b1;
                                    res.item.carve_length = 32'(pss_next);
                                    res.item.outcome = asfw_pkg::OUT_REGION_END;
                                    dec_next = 1'b1;
                                end
                            end
                        end
                    end
                    asfw_pkg::PH_SIZE:
                    begin
                        rel = pos_w - sfs_next;
                        if (pos_w >= sfs_next && rel < asfw_pkg::SIZE_LEN)
                        begin
                            obj_v = obj_next | (64'(item.data_byte) << {rel[2:0], 3'b000});
                            obj_next = obj_v;
                            if (rel[2:0] == 3'd7)
                            begin
                                bad = (obj_v < 64'(asfw_pkg::MIN_OBJ_SIZE))
                                    || (|obj_v[63:asfw_pkg::OFS_BITS])
                                    || (obj_v[asfw_pkg::OFS_BITS-1:0] > limit);
                                if (bad)
                                begin
                                    res.emit = 1'b1;
                                    res.item.carve_length =
                                        32'(sfs_next + asfw_pkg::GUID_LEN);
                                    res.item.outcome = asfw_pkg::OUT_BAD_SIZE;
                                    dec_next = 1'b1;
                                end
                                else
                                begin
                                    pss_next = sfs_next;
                                    gs_next = sfs_next + obj_v[asfw_pkg::OFS_BITS-1:0]
                                        - asfw_pkg::GUID_LEN;
                                    flags_next = '1;
                                    phase_next = asfw_pkg::PH_GUID;
                                end
                            end
                        end
                    end
                    asfw_pkg::PH_GUID:
                    begin
                        rel = pos_w - gs_next;
                        if (pos_w >= gs_next && rel < asfw_pkg::GUID_LEN)
                        begin
                            flags_v = flags_next;
                            for (int i = 0; i < 4; i++)
                            begin
                                if (item.data_byte != asfw_pkg::KNOWN_GUID[i][rel[3:0]])
                                    flags_v[i] = 1'b0;
                            end
                            flags_next = flags_v;
                            if (flags_v == 4'd0)
                            begin
                                res.emit = 1'b1;
                                res.item.carve_length = 32'(pss_next);
                                res.item.outcome = asfw_pkg::OUT_UNKNOWN_GUID;
                                dec_next = 1'b1;
                            end
                            else if (rel[3:0] == 4'd15)
                            begin
                                sfs_next = gs_next + asfw_pkg::GUID_LEN;
                                phase_next = asfw_pkg::PH_SIZE;
                                obj_next = '0;
                                // next size field at gs+16 must leave 24 bytes
                                if (!(gs_next + asfw_pkg::NEXT_GUID_GAP < rt_w))
                                begin
                                    res.emit = 1'b1;
                                    res.item.carve_length = 32'(pss_next);
                                    res.item.outcome = asfw_pkg::OUT_REGION_END;
                                    dec_next = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (item.region_end)
            begin
                if (!dec_next)
                begin
                    res.emit = 1'b1;
                    if (phase_next == asfw_pkg::PH_HEADER)
                    begin
                        res.item.carve_length = '0;
                        res.item.outcome = asfw_pkg::OUT_HDR_MISMATCH;
                    end
                    else
                    begin
                        res.item.carve_length = 32'(pss_next);
                        res.item.outcome = asfw_pkg::OUT_REGION_END;
                    end
                    dec_next = 1'b1;
                end
                phase_next = asfw_pkg::PH_IDLE;
            end

            if (pos_next != asfw_pkg::POS_MAX)
                pos_next = pos_next + 1'b1;
        end
    end

endmodule

// File: hw/rtl/asf_object_chain_walker.sv
// A result is registered: the byte that decides it passes the input register, then the
// walker logic into the result register.
// Throughput: one byte per cycle; a result held by result_stall stops the walker,
// and one more byte can wait in the input register before the input stalls.
// Reset (rst_n low, asynchronous) empties both registers and returns the walker to idle
// with no open region.
module asf_object_chain_walker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  asfw_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output asfw_pkg::out_item_t result
);

    asfw_pkg::in_item_t     in_reg;
    logic                   in_valid_reg, in_valid_next;
    asfw_pkg::out_item_t    out_reg;
    logic                   out_valid_reg, out_valid_next;
    asfw_pkg::step_result_t step_res;
    logic                   step;
    logic                   accept;

    // the buffered byte moves on when the result register can take a result
    assign step       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !step;
    assign accept     = item_valid && !item_stall;

    asfw_walker u_walker
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_reg),
        .res   (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = step_res.emit;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= item;
        if (step && step_res.emit)
            out_reg <= step_res.item;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: sim/testbench.sv
module testbench;

    import asfw_pkg::*;

    localparam int QUIET_LIMIT = 6000;
    localparam int LONG_HOLD   = 1500;

    typedef struct {
        in_item_t    payload;
        int unsigned gap;
        bit          drain;
    } feed_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    in_item_t    item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_item_t   result;

    // bytes waiting to be offered, and carves predicted but not yet seen
    feed_t       byte_feed[$];
    out_item_t   expected_carves[$];

    // chain walker prediction state
    logic [63:0] w_pos;
    logic [63:0] w_total;
    logic [63:0] w_size_ofs;
    logic [63:0] w_prev_ofs;
    logic [63:0] w_obj_size;
    logic [63:0] w_guid_ofs;
    logic [3:0]  w_alive;
    phase_t      w_phase;
    bit          w_done;

    // region under construction
    logic [7:0]  region_img[];
    int          size_offs[$];
    int          guid_offs[$];

    bit          fast_feed;
    bit          drain_next;
    bit          recv_calm;
    int          feed_wait;
    int          hold_left;
    int          quiet_cycles;
    int          bytes_queued;
    int          bytes_taken;
    int          regions_queued;
    int          results_seen;
    int          mismatches;
    int          outcome_tally[4];
    out_item_t   predicted;
    out_item_t   due;

    asf_object_chain_walker uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void walker_reset();
        w_pos      = '0;
        w_total    = '0;
        w_size_ofs = 64'd16;
        w_prev_ofs = '0;
        w_obj_size = '0;
        w_guid_ofs = '0;
        w_alive    = 4'hF;
        w_phase    = PH_IDLE;
        w_done     = 1'b0;
    endfunction

    function automatic bit conclude(input logic [63:0] len, input logic [1:0] code,
                                    output out_item_t res);
        res.carve_length = len[31:0];
        res.outcome      = code;
        w_done           = 1'b1;
        return 1'b1;
    endfunction

    // start on the size field at w_size_ofs, or stop if it cannot fit
    function automatic bit open_size_field(output out_item_t res);
        w_phase    = PH_SIZE;
        w_obj_size = '0;
        res        = '0;
        if (!(w_size_ofs + 24 < w_total))
            return conclude(w_prev_ofs, OUT_REGION_END, res);
        return 1'b0;
    endfunction

    function automatic bit walk_byte(input in_item_t it, output out_item_t res);
        bit          hit;
        logic [63:0] k;
        hit = 1'b0;
        res = '0;
        if (it.region_start)
        begin
            walker_reset();
            w_total = 64'(it.region_bytes);
            w_phase = PH_HEADER;
        end
        if (w_phase == PH_IDLE)
            return 1'b0;
        if (!w_done)
        begin
            case (w_phase)
                PH_HEADER:
                begin
                    if (w_pos < 16)
                    begin
                        if (it.data_byte != HDR_GUID[w_pos[3:0]])
                            hit = conclude(64'd0, OUT_HDR_MISMATCH, res);
                        else if (w_pos == 15)
                            hit = open_size_field(res);
                    end
                end
                PH_SIZE:
                begin
                    if (w_pos >= w_size_ofs && w_pos < w_size_ofs + 8)
                    begin
                        k = w_pos - w_size_ofs;
                        w_obj_size |= 64'(it.data_byte) << (8 * k[2:0]);
                        if (k == 7)
                        begin
                            if (w_obj_size < 24 || w_obj_size - 16 > w_total - w_size_ofs)
                                hit = conclude(w_size_ofs + 16, OUT_BAD_SIZE, res);
                            else
                            begin
                                w_prev_ofs = w_size_ofs;
                                w_guid_ofs = w_size_ofs + w_obj_size - 16;
                                w_alive    = 4'hF;
                                w_phase    = PH_GUID;
                            end
                        end
                    end
                end
                PH_GUID:
                begin
                    if (w_pos >= w_guid_ofs && w_pos < w_guid_ofs + 16)
                    begin
                        k = w_pos - w_guid_ofs;
                        for (int i = 0; i < 4; i++)
                            if (it.data_byte != KNOWN_GUID[i][k[3:0]])
                                w_alive[i] = 1'b0;
                        if (w_alive == 4'h0)
                            hit = conclude(w_prev_ofs, OUT_UNKNOWN_GUID, res);
                        else if (k == 15)
                        begin
                            w_size_ofs = w_guid_ofs + 16;
                            hit = open_size_field(res);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (it.region_end)
        begin
            if (!w_done)
            begin
                if (w_phase == PH_HEADER)
                    hit = conclude(64'd0, OUT_HDR_MISMATCH, res);
                else
                    hit = conclude(w_prev_ofs, OUT_REGION_END, res);
            end
            w_phase = PH_IDLE;
        end
        if (w_pos < 64'hFFFF_FFFF)
            w_pos++;
        return hit;
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit st, input bit en,
                             input logic [31:0] total);
        feed_t f;
        f.payload.data_byte    = b;
        f.payload.region_start = st;
        f.payload.region_end   = en;
        f.payload.region_bytes = st ? total : 32'($urandom_range(25, 32'hFFFF_FFFF));
        f.gap   = fast_feed ? 0 : $urandom_range(0, 8);
        f.drain = drain_next;
        drain_next = 1'b0;
        byte_feed.push_back(f);
        bytes_queued++;
        if (st)
            regions_queued++;
    endtask

    task automatic put_size(input int p, input logic [63:0] v);
        for (int j = 0; j < 8; j++)
            if (p + j < region_img.size())
                region_img[p + j] = v[8*j +: 8];
    endtask

    task automatic put_guid(input int g, input int which);
        for (int j = 0; j < 16; j++)
            if (g + j < region_img.size())
                region_img[g + j] = KNOWN_GUID[which][j];
    endtask

    // header, then objects of legal size each followed by a known GUID
    task automatic build_chain(input int n);
        int p;
        int room;
        int s;
        int g;
        region_img = new[n];
        for (int i = 0; i < n; i++)
            region_img[i] = 8'($urandom);
        for (int i = 0; i < 16; i++)
            region_img[i] = HDR_GUID[i];
        size_offs.delete();
        guid_offs.delete();
        p = 16;
        while (p + 24 < n)
        begin
            room = n - p + 16;
            case ($urandom_range(0, 9))
                0:       s = room;
                1:       s = 24;
                default: s = $urandom_range(24, (room < 64) ? room : 64);
            endcase
            put_size(p, 64'(s));
            size_offs.push_back(p);
            g = p + s - 16;
            put_guid(g, $urandom_range(0, 3));
            guid_offs.push_back(g);
            p = g + 16;
        end
    endtask

    task automatic send_region(input logic [31:0] total, input int n_send, input bit close);
        for (int i = 0; i < n_send; i++)
            push_byte(region_img[i], i == 0, close && i == n_send - 1, total);
    endtask

    // sender: one transfer per accepted byte, prediction made at the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            feed_wait  = 0;
            walker_reset();
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (walk_byte(item, predicted))
                    expected_carves.push_back(predicted);
                bytes_taken++;
            end
            if (!(item_valid && item_stall))
            begin
                if (feed_wait > 0)
                begin
                    feed_wait--;
                    item_valid <= 1'b0;
                end
                else if (byte_feed.size() > 0 &&
                         !(byte_feed[0].drain && expected_carves.size() > 0))
                begin
                    item_valid <= 1'b1;
                    item       <= byte_feed[0].payload;
                    feed_wait  = byte_feed[0].gap;
                    void'(byte_feed.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transfer, then draws its next hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_carves.size() == 0)
                    flag_mismatch($sformatf("unexpected result: carve_length %0d outcome %0d",
                                            result.carve_length, result.outcome));
                else
                begin
                    due = expected_carves.pop_front();
                    outcome_tally[due.outcome]++;
                    if (result.carve_length !== due.carve_length)
                        flag_mismatch($sformatf("result %0d: carve_length %0d, expected %0d",
                                                results_seen, result.carve_length,
                                                due.carve_length));
                    if (result.outcome !== due.outcome)
                        flag_mismatch($sformatf("result %0d: outcome %0d, expected %0d",
                                                results_seen, result.outcome, due.outcome));
                end
                // long hold-off lets results back up until the input stalls
                if (results_seen == 6 || results_seen == 15)
                    hold_left = LONG_HOLD;
                else
                begin
                    if ($urandom_range(0, 11) == 0)
                        recv_calm = !recv_calm;
                    hold_left = recv_calm ? 0 : $urandom_range(0, 8);
                end
            end
            else if (hold_left > 0)
                hold_left--;
            result_stall <= (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          n;
        int          n_send;
        int          kind;
        int          p;
        int          g;
        int          k;
        int          other;
        bit          close;
        logic [31:0] total;
        logic [63:0] bad;

        // directed part
        fast_feed = 1'b0;
        // no region open: ignored even with region_end set
        push_byte(8'hFF, 1'b0, 1'b1, 32'd25);
        // one-byte region, ends during the header
        push_byte(HDR_GUID[0], 1'b1, 1'b1, 32'hFFFF_FFFF);
        // mismatch on the first byte, the rest of the region is ignored
        push_byte(8'h00, 1'b1, 1'b0, 32'd25);
        push_byte(HDR_GUID[1], 1'b0, 1'b0, 32'd25);
        push_byte(8'hFF, 1'b0, 1'b1, 32'd25);
        // partial header abandoned by a restart
        push_byte(HDR_GUID[0], 1'b1, 1'b0, 32'd4000);
        push_byte(HDR_GUID[1], 1'b0, 1'b0, 32'd25);
        push_byte(HDR_GUID[2], 1'b0, 1'b0, 32'd25);
        push_byte(8'h31, 1'b1, 1'b1, 32'd100);
        // full header in the smallest region: no room for a size field
        for (int i = 0; i < 16; i++)
            push_byte(HDR_GUID[i], i == 0, i == 15, 32'd25);

        // random regions, mostly well-formed chains with one fault injected
        drain_next = 1'b1;
        while (bytes_queued < 1700)
        begin
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(300, 600)
                                             : $urandom_range(41, 130);
            build_chain(n);
            total  = 32'(n);
            n_send = n;
            close  = 1'b1;
            fast_feed = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                p = $urandom_range(0, 15);
                region_img[p] ^= 8'($urandom_range(1, 255));
                n_send = p + 1 + $urandom_range(0, 4);
            end
            else if (kind < 30 && size_offs.size() > 0)
            begin
                p = size_offs[$urandom_range(0, size_offs.size() - 1)];
                case ($urandom_range(0, 2))
                    0:       bad = 64'($urandom_range(0, 23));
                    1:       bad = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
                    default: bad = 64'(n - p + 17);
                endcase
                put_size(p, bad);
            end
            else if (kind < 45 && guid_offs.size() > 0)
            begin
                g = guid_offs[$urandom_range(0, guid_offs.size() - 1)];
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 1) == 0)
                begin
                    // known prefix followed by the tail of a randomly chosen known GUID, possibly the same one
                    other = $urandom_range(0, 3);
                    for (int j = k; j < 16; j++)
                        if (g + j < n)
                            region_img[g + j] = KNOWN_GUID[other][j];
                end
                else if (g + k < n)
                    region_img[g + k] ^= 8'($urandom_range(1, 255));
            end
            else if (kind < 55)
                n_send = $urandom_range(1, n - 1);
            else if (kind < 62)
                close = 1'b0;
            else if (kind < 70)
                total = 32'($urandom_range(n, 32'hFFFF_FFFF));
            else if (kind < 76)
                total = 32'($urandom_range(25, n));
            if (n_send > n)
                n_send = n;
            send_region(total, n_send, close);
            if (close && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 32'd25);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < bytes_queued || expected_carves.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_carves.size() > 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    expected_carves.size()));
        $display("Walked %0d regions over %0d byte transfers; %0d results checked",
                 regions_queued, bytes_taken, results_seen);
        $display("Outcomes: %0d header mismatch, %0d bad size, %0d unknown GUID, %0d chain end",
                 outcome_tally[OUT_HDR_MISMATCH], outcome_tally[OUT_BAD_SIZE],
                 outcome_tally[OUT_UNKNOWN_GUID], outcome_tally[OUT_REGION_END]);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
